FILE: design/tilemap_box_move_collision_unit_assert.svh
// ----------------------------------------------------------------------------
// Tilemap box move collision unit: assertion macros
// Concurrent checks clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef TILEMAP_BOX_MOVE_COLLISION_UNIT_ASSERT_SVH
`define TILEMAP_BOX_MOVE_COLLISION_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define TBMC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

`define TBMC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TBMC_ASSERT(name, prop, msg)

`define TBMC_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

FILE: design/tbmc_pkg.sv
// ----------------------------------------------------------------------------
// Tilemap box move collision package
// Map geometry, field widths, request codes and the sequencer microcode.
// ----------------------------------------------------------------------------
package tbmc_pkg;

    localparam int MAP_TILES_X = 64;
    localparam int MAP_TILES_Y = 64;
    localparam int TILE_SHIFT  = 9;

    localparam int MAP_DEPTH = MAP_TILES_X * MAP_TILES_Y;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);

    localparam int POS_W     = 17;
    localparam int DELTA_W   = 10;
    localparam int HALF_W    = 10;
    localparam int TILE_W    = 6;
    localparam int REQ_W     = 2;
    localparam int REG_IDX_W = 1;
    localparam int EDGE_W    = POS_W + 2;

    localparam logic [REQ_W-1:0] REQ_TILE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PLACE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MOVE  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_HALF_HEIGHT = 1'd1;

    localparam logic [HALF_W-1:0] HALF_RESET = 10'd256;

    localparam logic signed [EDGE_W-1:0] POS_MIN_E = -(EDGE_W'(1) <<< (POS_W - 1));
    localparam logic signed [EDGE_W-1:0] POS_MAX_E = (EDGE_W'(1) <<< (POS_W - 1)) - 1;
    localparam logic signed [EDGE_W-1:0] MAP_X_E   = EDGE_W'(MAP_TILES_X);
    localparam logic signed [EDGE_W-1:0] MAP_Y_E   = EDGE_W'(MAP_TILES_Y);

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_WAIT     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_TRIAL_X  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_EDGES_X  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_CHECK_X  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SCAN_X   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_COMMIT_X = 4'd5;
    localparam logic [STEP_W-1:0] STEP_TRIAL_Y  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_EDGES_Y  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CHECK_Y  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_SCAN_Y   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_COMMIT_Y = 4'd10;
    localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd11;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_TRIAL_X,
        OP_TRIAL_Y,
        OP_EDGES,
        OP_CHECK,
        OP_SCAN,
        OP_COMMIT_X,
        OP_COMMIT_Y,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_ACCEPT,
        COND_DECIDED,
        COND_SCAN,
        COND_EMIT
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            STEP_WAIT:     w = '{op: OP_WAIT,     cond: COND_ACCEPT,  target: STEP_EMIT};
            STEP_TRIAL_X:  w = '{op: OP_TRIAL_X,  cond: COND_NEXT,    target: STEP_WAIT};
            STEP_EDGES_X:  w = '{op: OP_EDGES,    cond: COND_NEXT,    target: STEP_WAIT};
            STEP_CHECK_X:  w = '{op: OP_CHECK,    cond: COND_DECIDED, target: STEP_COMMIT_X};
            STEP_SCAN_X:   w = '{op: OP_SCAN,     cond: COND_SCAN,    target: STEP_COMMIT_X};
            STEP_COMMIT_X: w = '{op: OP_COMMIT_X, cond: COND_NEXT,    target: STEP_WAIT};
            STEP_TRIAL_Y:  w = '{op: OP_TRIAL_Y,  cond: COND_NEXT,    target: STEP_WAIT};
            STEP_EDGES_Y:  w = '{op: OP_EDGES,    cond: COND_NEXT,    target: STEP_WAIT};
            STEP_CHECK_Y:  w = '{op: OP_CHECK,    cond: COND_DECIDED, target: STEP_COMMIT_Y};
            STEP_SCAN_Y:   w = '{op: OP_SCAN,     cond: COND_SCAN,    target: STEP_COMMIT_Y};
            STEP_COMMIT_Y: w = '{op: OP_COMMIT_Y, cond: COND_NEXT,    target: STEP_WAIT};
            STEP_EMIT:     w = '{op: OP_EMIT,     cond: COND_EMIT,    target: STEP_WAIT};
            default:       w = '{op: OP_NOP,      cond: COND_JUMP,    target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: design/tbmc_ram.sv
// ----------------------------------------------------------------------------
// Tilemap box move collision RAM
// Single-port RAM with one write or read per cycle and registered read data.
// ----------------------------------------------------------------------------
module tbmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/tilemap_box_move_collision_unit.sv
// ----------------------------------------------------------------------------
// Tilemap box move collision unit
// Moves an axis-aligned box over a passable/blocked tile map, X then Y.
// ----------------------------------------------------------------------------
// One item is worked at a time by a microcoded step sequencer over a single
// tile-map RAM port. A tile write, a placement or an unused request code
// goes from acceptance through the emit step. A move runs the trial, edges,
// check, scan and commit steps for X, then for Y, then the emit step. The
// scan reads one tile per cycle, stopping at the first blocked tile, and is
// skipped when the trial leaves the position range, touches outside the
// map or covers no tile. The result sits in an output register, so the
// next item is taken while it waits. The tile map has no reset; every tile
// a box can reach must be written before a move reads it.
module tilemap_box_move_collision_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [tbmc_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [tbmc_pkg::HALF_W-1:0]          cfg_wdata,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tbmc_pkg::REQ_W-1:0]           s_req_type,
    input  logic [tbmc_pkg::TILE_W-1:0]          s_tile_x,
    input  logic [tbmc_pkg::TILE_W-1:0]          s_tile_y,
    input  logic                                 s_tile_passable,
    input  logic signed [tbmc_pkg::POS_W-1:0]    s_place_x,
    input  logic signed [tbmc_pkg::POS_W-1:0]    s_place_y,
    input  logic signed [tbmc_pkg::DELTA_W-1:0]  s_delta_x,
    input  logic signed [tbmc_pkg::DELTA_W-1:0]  s_delta_y,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [tbmc_pkg::POS_W-1:0]    m_pos_x,
    output logic signed [tbmc_pkg::POS_W-1:0]    m_pos_y,
    output logic                                 m_blocked_x,
    output logic                                 m_blocked_y
);

    `include "tilemap_box_move_collision_unit_assert.svh"

    localparam int EW = tbmc_pkg::EDGE_W;
    localparam int AW = tbmc_pkg::ADDR_W;

    tbmc_pkg::ucode_t cw;

    logic [tbmc_pkg::STEP_W-1:0]         pc_reg, pc_next;
    logic signed [tbmc_pkg::POS_W-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic signed [tbmc_pkg::DELTA_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [tbmc_pkg::HALF_W-1:0]         hw_reg, hw_next, hh_reg, hh_next;
    logic signed [EW-1:0]                trial_x_reg, trial_x_next;
    logic signed [EW-1:0]                trial_y_reg, trial_y_next;
    logic signed [EW-1:0]                gx0_reg, gx0_next, gx1_reg, gx1_next;
    logic signed [EW-1:0]                gy0_reg, gy0_next, gy1_reg, gy1_next;
    logic signed [EW-1:0]                gx_reg, gx_next, gy_reg, gy_next;
    logic                                blk_reg, blk_next;
    logic                                bx_reg, bx_next, by_reg, by_next;
    logic                                m_valid_reg, m_valid_next;
    logic signed [tbmc_pkg::POS_W-1:0]   m_pos_x_reg, m_pos_x_next;
    logic signed [tbmc_pkg::POS_W-1:0]   m_pos_y_reg, m_pos_y_next;
    logic                                m_blocked_x_reg, m_blocked_x_next;
    logic                                m_blocked_y_reg, m_blocked_y_next;

    logic                 in_accept, out_free;
    logic signed [EW-1:0] cx_ext, cy_ext, dx_ext, dy_ext, hw_ext, hh_ext;
    logic signed [EW-1:0] edge_xl, edge_xr, edge_yt, edge_yb;
    logic                 ovf, empty_span, outside, decided;
    logic                 last_col, scan_last, scan_stop;
    logic signed [EW-1:0] nxt_gx, nxt_gy;
    logic                 tile_in_map;
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic                 ram_rdata;

    assign cw        = tbmc_pkg::ucode_rom(pc_reg);
    assign s_ready   = (cw.op == tbmc_pkg::OP_WAIT);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign cx_ext = EW'(cx_reg);
    assign cy_ext = EW'(cy_reg);
    assign dx_ext = EW'(dx_reg);
    assign dy_ext = EW'(dy_reg);
    assign hw_ext = EW'(hw_reg);
    assign hh_ext = EW'(hh_reg);

    assign edge_xl = trial_x_reg - hw_ext;
    assign edge_xr = trial_x_reg + hw_ext - EW'(1);
    assign edge_yt = trial_y_reg - hh_ext;
    assign edge_yb = trial_y_reg + hh_ext - EW'(1);

    assign ovf = (trial_x_reg < tbmc_pkg::POS_MIN_E) || (trial_x_reg > tbmc_pkg::POS_MAX_E)
              || (trial_y_reg < tbmc_pkg::POS_MIN_E) || (trial_y_reg > tbmc_pkg::POS_MAX_E);
    assign empty_span = (gx1_reg < gx0_reg) || (gy1_reg < gy0_reg);
    assign outside    = (gx0_reg < 0) || (gy0_reg < 0)
                     || (gx1_reg >= tbmc_pkg::MAP_X_E) || (gy1_reg >= tbmc_pkg::MAP_Y_E);
    assign decided    = ovf || empty_span || outside;

    assign last_col  = (gx_reg == gx1_reg);
    assign scan_last = last_col && (gy_reg == gy1_reg);
    assign scan_stop = !ram_rdata || scan_last;
    assign nxt_gx    = last_col ? gx0_reg : gx_reg + EW'(1);
    assign nxt_gy    = last_col ? gy_reg + EW'(1) : gy_reg;

    assign tile_in_map = (int'(s_tile_x) < tbmc_pkg::MAP_TILES_X)
                      && (int'(s_tile_y) < tbmc_pkg::MAP_TILES_Y);

    always_comb begin
        ram_we = 1'b0;
        case (cw.op)
            tbmc_pkg::OP_WAIT: begin
                ram_we   = in_accept && (s_req_type == tbmc_pkg::REQ_TILE) && tile_in_map;
                ram_addr = AW'(int'(s_tile_y) * tbmc_pkg::MAP_TILES_X + int'(s_tile_x));
            end
            tbmc_pkg::OP_SCAN: begin
                ram_addr = AW'(int'(nxt_gy) * tbmc_pkg::MAP_TILES_X + int'(nxt_gx));
            end
            default: begin
                ram_addr = AW'(int'(gy_reg) * tbmc_pkg::MAP_TILES_X + int'(gx_reg));
            end
        endcase
    end

    tbmc_ram #(
        .WIDTH (1),
        .DEPTH (tbmc_pkg::MAP_DEPTH)
    ) u_tile_map (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_tile_passable),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        case (cw.cond)
            tbmc_pkg::COND_NEXT:    pc_next = pc_reg + 1'b1;
            tbmc_pkg::COND_JUMP:    pc_next = cw.target;
            tbmc_pkg::COND_ACCEPT: begin
                if (!in_accept) begin
                    pc_next = pc_reg;
                end else if (s_req_type == tbmc_pkg::REQ_MOVE) begin
                    pc_next = pc_reg + 1'b1;
                end else begin
                    pc_next = cw.target;
                end
            end
            tbmc_pkg::COND_DECIDED: pc_next = decided ? cw.target : pc_reg + 1'b1;
            tbmc_pkg::COND_SCAN:    pc_next = scan_stop ? cw.target : pc_reg;
            tbmc_pkg::COND_EMIT:    pc_next = out_free ? cw.target : pc_reg;
            default:                pc_next = tbmc_pkg::STEP_WAIT;
        endcase
    end

    // datapath
    always_comb begin
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        hw_next          = hw_reg;
        hh_next          = hh_reg;
        trial_x_next     = trial_x_reg;
        trial_y_next     = trial_y_reg;
        gx0_next         = gx0_reg;
        gx1_next         = gx1_reg;
        gy0_next         = gy0_reg;
        gy1_next         = gy1_reg;
        gx_next          = gx_reg;
        gy_next          = gy_reg;
        blk_next         = blk_reg;
        bx_next          = bx_reg;
        by_next          = by_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_pos_x_next     = m_pos_x_reg;
        m_pos_y_next     = m_pos_y_reg;
        m_blocked_x_next = m_blocked_x_reg;
        m_blocked_y_next = m_blocked_y_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                tbmc_pkg::REG_HALF_WIDTH:  hw_next = cfg_wdata;
                tbmc_pkg::REG_HALF_HEIGHT: hh_next = cfg_wdata;
                default: ;
            endcase
        end

        case (cw.op)
            tbmc_pkg::OP_WAIT: begin
                if (in_accept) begin
                    bx_next = 1'b0;
                    by_next = 1'b0;
                    dx_next = s_delta_x;
                    dy_next = s_delta_y;
                    if (s_req_type == tbmc_pkg::REQ_PLACE) begin
                        cx_next = s_place_x;
                        cy_next = s_place_y;
                    end
                end
            end
            tbmc_pkg::OP_TRIAL_X: begin
                trial_x_next = cx_ext + dx_ext;
                trial_y_next = cy_ext;
            end
            tbmc_pkg::OP_TRIAL_Y: begin
                trial_x_next = cx_ext;
                trial_y_next = cy_ext + dy_ext;
            end
            tbmc_pkg::OP_EDGES: begin
                gx0_next = edge_xl >>> tbmc_pkg::TILE_SHIFT;
                gx1_next = edge_xr >>> tbmc_pkg::TILE_SHIFT;
                gy0_next = edge_yt >>> tbmc_pkg::TILE_SHIFT;
                gy1_next = edge_yb >>> tbmc_pkg::TILE_SHIFT;
                gx_next  = edge_xl >>> tbmc_pkg::TILE_SHIFT;
                gy_next  = edge_yt >>> tbmc_pkg::TILE_SHIFT;
            end
            tbmc_pkg::OP_CHECK: begin
                blk_next = ovf || (!empty_span && outside);
            end
            tbmc_pkg::OP_SCAN: begin
                blk_next = !ram_rdata;
                gx_next  = nxt_gx;
                gy_next  = nxt_gy;
            end
            tbmc_pkg::OP_COMMIT_X: begin
                bx_next = blk_reg;
                if (!blk_reg) begin
                    cx_next = trial_x_reg[tbmc_pkg::POS_W-1:0];
                end
            end
            tbmc_pkg::OP_COMMIT_Y: begin
                by_next = blk_reg;
                if (!blk_reg) begin
                    cy_next = trial_y_reg[tbmc_pkg::POS_W-1:0];
                end
            end
            tbmc_pkg::OP_EMIT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_pos_x_next     = cx_reg;
                    m_pos_y_next     = cy_reg;
                    m_blocked_x_next = bx_reg;
                    m_blocked_y_next = by_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= tbmc_pkg::STEP_WAIT;
            cx_reg      <= '0;
            cy_reg      <= '0;
            hw_reg      <= tbmc_pkg::HALF_RESET;
            hh_reg      <= tbmc_pkg::HALF_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            hw_reg      <= hw_next;
            hh_reg      <= hh_next;
            m_valid_reg <= m_valid_next;
        end
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        trial_x_reg     <= trial_x_next;
        trial_y_reg     <= trial_y_next;
        gx0_reg         <= gx0_next;
        gx1_reg         <= gx1_next;
        gy0_reg         <= gy0_next;
        gy1_reg         <= gy1_next;
        gx_reg          <= gx_next;
        gy_reg          <= gy_next;
        blk_reg         <= blk_next;
        bx_reg          <= bx_next;
        by_reg          <= by_next;
        m_pos_x_reg     <= m_pos_x_next;
        m_pos_y_reg     <= m_pos_y_next;
        m_blocked_x_reg <= m_blocked_x_next;
        m_blocked_y_reg <= m_blocked_y_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_pos_x     = m_pos_x_reg;
    assign m_pos_y     = m_pos_y_reg;
    assign m_blocked_x = m_blocked_x_reg;
    assign m_blocked_y = m_blocked_y_reg;

    `TBMC_ASSERT(a_beat_from_emit, $rose(m_valid_reg) |-> $past(pc_reg) == tbmc_pkg::STEP_EMIT, "result beat raised outside the emit step")
    `TBMC_ASSERT(a_cx_writers, !$stable(cx_reg) |-> ($past(pc_reg) == tbmc_pkg::STEP_WAIT || $past(pc_reg) == tbmc_pkg::STEP_COMMIT_X), "center x changed outside placement or x commit")
    `TBMC_ASSERT(a_cy_writers, !$stable(cy_reg) |-> ($past(pc_reg) == tbmc_pkg::STEP_WAIT || $past(pc_reg) == tbmc_pkg::STEP_COMMIT_Y), "center y changed outside placement or y commit")
    `TBMC_ASSERT(a_scan_in_map, (cw.op == tbmc_pkg::OP_SCAN) |-> (gx_reg >= 0 && gy_reg >= 0 && gx_reg < tbmc_pkg::MAP_X_E && gy_reg < tbmc_pkg::MAP_Y_E), "tile scan left the map")
    `TBMC_ASSERT_NEXT(a_accept_leaves_wait, in_accept, pc_reg != tbmc_pkg::STEP_WAIT, "accepted beat did not advance the sequencer")

endmodule

FILE: dv/tbmc_move_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box move checker
// Watches the config port and both channels of the box move collision unit,
// keeps its own tile map, box center and box size, predicts the report of
// every accepted request beat and compares each report beat, field by field,
// with the oldest prediction. Mismatch and pending counts go to the top.
// ----------------------------------------------------------------------------
module tbmc_move_checker
    import tbmc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_wr_en,
    input  logic [REG_IDX_W-1:0]       cfg_index,
    input  logic [HALF_W-1:0]          cfg_wdata,

    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [REQ_W-1:0]           s_req_type,
    input  logic [TILE_W-1:0]          s_tile_x,
    input  logic [TILE_W-1:0]          s_tile_y,
    input  logic                       s_tile_passable,
    input  logic signed [POS_W-1:0]    s_place_x,
    input  logic signed [POS_W-1:0]    s_place_y,
    input  logic signed [DELTA_W-1:0]  s_delta_x,
    input  logic signed [DELTA_W-1:0]  s_delta_y,

    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [POS_W-1:0]    m_pos_x,
    input  logic signed [POS_W-1:0]    m_pos_y,
    input  logic                       m_blocked_x,
    input  logic                       m_blocked_y,

    output int                         fault_count,
    output int                         pending
);

    localparam int POS_LO = -(1 << (POS_W - 1));
    localparam int POS_HI = (1 << (POS_W - 1)) - 1;

    typedef struct {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    blocked_x;
        logic                    blocked_y;
    } box_report_t;

    logic                    tile_open [MAP_DEPTH];
    logic signed [POS_W-1:0] box_x;
    logic signed [POS_W-1:0] box_y;
    logic [HALF_W-1:0]       half_w;
    logic [HALF_W-1:0]       half_h;
    box_report_t             owed_reports [$];
    int                      faults = 0;

    initial begin
        fault_count = 0;
        pending = 0;
        box_x = '0;
        box_y = '0;
        half_w = HALF_RESET;
        half_h = HALF_RESET;
    end

    function automatic logic box_hits_wall(input int cx, input int cy);
        int gx0;
        int gx1;
        int gy0;
        int gy1;
        int gx;
        int gy;
        gx0 = (cx - int'(half_w)) >>> TILE_SHIFT;
        gx1 = (cx + int'(half_w) - 1) >>> TILE_SHIFT;
        gy0 = (cy - int'(half_h)) >>> TILE_SHIFT;
        gy1 = (cy + int'(half_h) - 1) >>> TILE_SHIFT;
        if (gx1 < gx0 || gy1 < gy0) begin
            return 1'b0;
        end
        if (gx0 < 0 || gy0 < 0 || gx1 >= MAP_TILES_X || gy1 >= MAP_TILES_Y) begin
            return 1'b1;
        end
        for (gy = gy0; gy <= gy1; gy++) begin
            for (gx = gx0; gx <= gx1; gx++) begin
                if (!tile_open[gy * MAP_TILES_X + gx]) begin
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic predict_report();
        box_report_t r;
        int nx;
        int ny;
        r.blocked_x = 1'b0;
        r.blocked_y = 1'b0;
        case (s_req_type)
            REQ_TILE: begin
                tile_open[int'(s_tile_y) * MAP_TILES_X + int'(s_tile_x)] = s_tile_passable;
            end
            REQ_PLACE: begin
                box_x = s_place_x;
                box_y = s_place_y;
            end
            REQ_MOVE: begin
                nx = int'(box_x) + int'(s_delta_x);
                if (nx < POS_LO || nx > POS_HI || box_hits_wall(nx, int'(box_y))) begin
                    r.blocked_x = 1'b1;
                end else begin
                    box_x = POS_W'(nx);
                end
                ny = int'(box_y) + int'(s_delta_y);
                if (ny < POS_LO || ny > POS_HI || box_hits_wall(int'(box_x), ny)) begin
                    r.blocked_y = 1'b1;
                end else begin
                    box_y = POS_W'(ny);
                end
            end
            default: begin
            end
        endcase
        r.pos_x = box_x;
        r.pos_y = box_y;
        owed_reports.push_back(r);
    endtask

    function automatic void flag_field(input string field, input int want, input int got);
        if (want != got) begin
            faults++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        box_report_t want;
        if (!aresetn) begin
            owed_reports.delete();
            box_x = '0;
            box_y = '0;
            half_w = HALF_RESET;
            half_h = HALF_RESET;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_HALF_WIDTH:  half_w = cfg_wdata;
                    REG_HALF_HEIGHT: half_h = cfg_wdata;
                    default: begin
                    end
                endcase
            end
            // compare the report first so a same-edge request cannot mask it
            if (m_valid && m_ready) begin
                if (owed_reports.size() == 0) begin
                    faults++;
                    $display("%0t: report beat with nothing expected, actual %0d %0d %0d %0d",
                             $time, m_pos_x, m_pos_y, m_blocked_x, m_blocked_y);
                end else begin
                    want = owed_reports.pop_front();
                    flag_field("pos_x", int'(want.pos_x), int'(m_pos_x));
                    flag_field("pos_y", int'(want.pos_y), int'(m_pos_y));
                    flag_field("blocked_x", int'(want.blocked_x), int'(m_blocked_x));
                    flag_field("blocked_y", int'(want.blocked_y), int'(m_blocked_y));
                end
            end
            if (s_valid && s_ready) begin
                predict_report();
            end
        end
        pending <= owed_reports.size();
        fault_count <= faults;
    end

endmodule

FILE: dv/tilemap_box_move_collision_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilemap box move collision unit testbench
// Fills a walled corner of the tile map, runs a directed set of placements,
// moves and tile writes, then random traffic under several box sizes with
// random idling on both channels. Boxes stay in the filled corner or off the
// map. A separate checker predicts and compares every report.
// ----------------------------------------------------------------------------
module tilemap_box_move_collision_unit_test;
    import tbmc_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int FILL_TILES      = 16;
    localparam int REGION_SPAN     = (FILL_TILES - 1) * (1 << TILE_SHIFT);
    localparam int POS_LO          = -(1 << (POS_W - 1));
    localparam int PHASES          = 7;
    localparam int BEATS_PER_PHASE = 190;
    localparam int SETTLE_CYCLES   = 100;

    typedef struct {
        logic [REQ_W-1:0]          req;
        logic [TILE_W-1:0]         tile_x;
        logic [TILE_W-1:0]         tile_y;
        logic                      passable;
        logic signed [POS_W-1:0]   place_x;
        logic signed [POS_W-1:0]   place_y;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
    } move_req_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0]       cfg_index = '0;
    logic [HALF_W-1:0]          cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [REQ_W-1:0]           s_req_type = '0;
    logic [TILE_W-1:0]          s_tile_x = '0;
    logic [TILE_W-1:0]          s_tile_y = '0;
    logic                       s_tile_passable = 1'b0;
    logic signed [POS_W-1:0]    s_place_x = '0;
    logic signed [POS_W-1:0]    s_place_y = '0;
    logic signed [DELTA_W-1:0]  s_delta_x = '0;
    logic signed [DELTA_W-1:0]  s_delta_y = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [POS_W-1:0]    m_pos_x;
    logic signed [POS_W-1:0]    m_pos_y;
    logic                       m_blocked_x;
    logic                       m_blocked_y;

    int fault_count;
    int pending;
    int cycles = 0;
    bit steady = 1'b0;

    tilemap_box_move_collision_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_tile_x        (s_tile_x),
        .s_tile_y        (s_tile_y),
        .s_tile_passable (s_tile_passable),
        .s_place_x       (s_place_x),
        .s_place_y       (s_place_y),
        .s_delta_x       (s_delta_x),
        .s_delta_y       (s_delta_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_blocked_x     (m_blocked_x),
        .m_blocked_y     (m_blocked_y)
    );

    tbmc_move_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_tile_x        (s_tile_x),
        .s_tile_y        (s_tile_y),
        .s_tile_passable (s_tile_passable),
        .s_place_x       (s_place_x),
        .s_place_y       (s_place_y),
        .s_delta_x       (s_delta_x),
        .s_delta_y       (s_delta_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_blocked_x     (m_blocked_x),
        .m_blocked_y     (m_blocked_y),
        .fault_count     (fault_count),
        .pending         (pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic move_req_t quiet_beat(input logic [REQ_W-1:0] req);
        move_req_t b;
        b.req = req;
        b.tile_x = '0;
        b.tile_y = '0;
        b.passable = 1'b0;
        b.place_x = '0;
        b.place_y = '0;
        b.delta_x = '0;
        b.delta_y = '0;
        return b;
    endfunction

    function automatic move_req_t tile_beat(input int tx, input int ty, input logic open);
        move_req_t b;
        b = quiet_beat(REQ_TILE);
        b.tile_x = TILE_W'(tx);
        b.tile_y = TILE_W'(ty);
        b.passable = open;
        return b;
    endfunction

    function automatic move_req_t place_beat(input int x, input int y);
        move_req_t b;
        b = quiet_beat(REQ_PLACE);
        b.place_x = POS_W'(x);
        b.place_y = POS_W'(y);
        return b;
    endfunction

    function automatic move_req_t move_beat(input int dx, input int dy);
        move_req_t b;
        b = quiet_beat(REQ_MOVE);
        b.delta_x = DELTA_W'(dx);
        b.delta_y = DELTA_W'(dy);
        return b;
    endfunction

    // mostly in-corner placements and short moves, with wide noise that
    // keeps the box clear of unfilled tiles
    function automatic move_req_t random_beat(input int hw, input int hh);
        move_req_t b;
        int pick;
        b.req = REQ_W'($urandom);
        b.tile_x = TILE_W'($urandom);
        b.tile_y = TILE_W'($urandom);
        b.passable = 1'($urandom);
        b.place_x = POS_W'($urandom);
        b.place_y = POS_W'($urandom);
        b.delta_x = DELTA_W'($urandom);
        b.delta_y = DELTA_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            b.req = REQ_TILE;
            b.passable = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 9) != 0) begin
                b.tile_x = TILE_W'($urandom_range(0, FILL_TILES - 2));
                b.tile_y = TILE_W'($urandom_range(0, FILL_TILES - 2));
            end
            // keep the corner wall closed
            if (int'(b.tile_x) == FILL_TILES - 1 || int'(b.tile_y) == FILL_TILES - 1) begin
                b.passable = 1'b0;
            end
        end else if (pick < 38) begin
            b.req = REQ_PLACE;
            if ($urandom_range(0, 9) != 0) begin
                b.place_x = POS_W'($urandom_range(0, REGION_SPAN - hw));
                b.place_y = POS_W'($urandom_range(0, REGION_SPAN - hh));
            end else begin
                b.place_x = POS_W'(POS_LO + int'($urandom_range(0, REGION_SPAN - hw - POS_LO)));
                b.place_y = POS_W'(POS_LO + int'($urandom_range(0, REGION_SPAN - hh - POS_LO)));
            end
        end else if (pick < 95) begin
            b.req = REQ_MOVE;
            if ($urandom_range(0, 3) != 0) begin
                b.delta_x = DELTA_W'(int'($urandom_range(0, 128)) - 64);
                b.delta_y = DELTA_W'(int'($urandom_range(0, 128)) - 64);
            end
            // hold a zero-size axis so an empty span never drifts off the corner
            if (hw == 0) begin
                b.delta_x = '0;
            end
            if (hh == 0) begin
                b.delta_y = '0;
            end
        end else begin
            b.req = REQ_UNUSED;
        end
        return b;
    endfunction

    task automatic send_beat(input move_req_t b);
        s_valid <= 1'b1;
        s_req_type <= b.req;
        s_tile_x <= b.tile_x;
        s_tile_y <= b.tile_y;
        s_tile_passable <= b.passable;
        s_place_x <= b.place_x;
        s_place_y <= b.place_y;
        s_delta_x <= b.delta_x;
        s_delta_y <= b.delta_y;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (!steady && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain_reports();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic load_box_size(input logic [HALF_W-1:0] hw, input logic [HALF_W-1:0] hh);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_HALF_WIDTH;
        cfg_wdata <= hw;
        @(posedge aclk);
        cfg_index <= REG_HALF_HEIGHT;
        cfg_wdata <= hh;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int tx;
        int ty;
        int ph;
        int n;
        int half_w_plan [PHASES];
        int half_h_plan [PHASES];
        half_w_plan = '{1, 1023, 0, 700, 256, 0, 0};
        half_h_plan = '{1, 1023, 300, 0, 256, 0, 0};
        half_w_plan[5] = $urandom_range(1, 1023);
        half_h_plan[5] = $urandom_range(1, 1023);
        half_w_plan[6] = $urandom_range(1, 1023);
        half_h_plan[6] = $urandom_range(1, 1023);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the corner, last row and column blocked as a wall
        for (ty = 0; ty < FILL_TILES; ty++) begin
            for (tx = 0; tx < FILL_TILES; tx++) begin
                send_beat(tile_beat(tx, ty, tx < FILL_TILES - 1 && ty < FILL_TILES - 1
                                    && $urandom_range(0, 9) != 0));
            end
        end

        send_beat(tile_beat(0, 0, 1'b0));
        send_beat(tile_beat(63, 63, 1'b1));
        send_beat(tile_beat(0, 0, 1'b1));
        send_beat(quiet_beat(REQ_UNUSED));
        send_beat(place_beat(-65536, 65535));
        send_beat(move_beat(-511, 511));
        send_beat(place_beat(65535, -65536));
        send_beat(move_beat(511, -511));
        send_beat(place_beat(3072, 3072));
        send_beat(move_beat(511, -511));
        send_beat(move_beat(-511, 511));
        send_beat(move_beat(-512, 0));
        send_beat(move_beat(0, 0));
        // box sits exactly on tile 10,10; a one-step x move touches the wall
        send_beat(tile_beat(10, 10, 1'b1));
        send_beat(tile_beat(11, 10, 1'b0));
        send_beat(tile_beat(10, 11, 1'b1));
        send_beat(place_beat(5376, 5376));
        send_beat(move_beat(0, 0));
        send_beat(move_beat(1, 1));
        send_beat(tile_beat(11, 10, 1'b1));

        for (ph = 0; ph < PHASES; ph++) begin
            drain_reports();
            load_box_size(HALF_W'(half_w_plan[ph]), HALF_W'(half_h_plan[ph]));
            send_beat(place_beat(REGION_SPAN / 2, REGION_SPAN / 2));
            steady = (ph == 4);
            for (n = 0; n < BEATS_PER_PHASE; n++) begin
                send_beat(random_beat(half_w_plan[ph], half_h_plan[ph]));
            end
        end
        steady = 1'b0;

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
